// File: hw/rtl/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int COUNT_W       = 5;
   localparam int CAP_W         = 5;
   localparam int APB_ADDR_W    = 3;
   localparam int APB_DATA_W    = 32;

   localparam logic [CAP_W-1:0]         CAP_RESET = 5'd16;
   localparam logic signed [WORD_W-1:0] NONE_WORD = '1;

   // register index, taken from the word address bit of paddr
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_FILL = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic signed [WORD_W-1:0] push_word;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_word;
      status_type               status;
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] rear_word;
      logic [COUNT_W-1:0]       entry_count;
      logic                     is_full;
      logic                     is_empty;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/bounded_double_ended_queue_unit.sv
// Top level of the bounded double-ended queue: APB register block and ring engine.
// Depends on bdq_pkg, bdq_csr, bdq_engine.
//
// An operation is taken when start is high and busy is low; its result appears on
// rsp_item for exactly one cycle with rsp_strobe, and must be captured then. For pushes
// and refused operations the result shows in the cycle after the beat and busy stays
// low, so a new operation may follow at once. A pop that leaves the queue non-empty
// holds busy high for one cycle while the new front or rear word is read back through
// the registered read port of the slot RAM; its result shows after that read.
// The queue is empty after reset; capacity resets to 16 and fill stops at DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module bounded_double_ended_queue_unit #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire bdq_pkg::req_type                req_item,
   output logic                                 rsp_strobe,
   output bdq_pkg::rsp_type                     rsp_item,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [bdq_pkg::APB_ADDR_W-1:0]  paddr,
   input  wire logic [bdq_pkg::APB_DATA_W-1:0]  pwdata,
   output logic      [bdq_pkg::APB_DATA_W-1:0]  prdata,
   output logic                                 pready
);

   logic [bdq_pkg::CAP_W-1:0] capacity;

   bdq_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   bdq_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .capacity   (capacity)
   );

endmodule

`default_nettype wire

// File: hw/rtl/bdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bdq_csr.sv
// APB register block holding the capacity register.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [bdq_pkg::APB_ADDR_W-1:0]   paddr,
   input  wire logic [bdq_pkg::APB_DATA_W-1:0]   pwdata,
   output logic      [bdq_pkg::APB_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output logic      [bdq_pkg::CAP_W-1:0]        capacity
);

   logic [bdq_pkg::CAP_W-1:0] capacity_ff;
   logic [bdq_pkg::CAP_W-1:0] capacity_in;
   logic                      reg_sel;

   assign reg_sel = (paddr[bdq_pkg::APB_ADDR_W-1] == bdq_pkg::REG_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && reg_sel) begin
         capacity_in = pwdata[bdq_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bdq_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_sel) begin
         prdata = {{(bdq_pkg::APB_DATA_W - bdq_pkg::CAP_W){1'b0}}, capacity_ff};
      end
   end

   assign pready   = 1'b1;
   assign capacity = capacity_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bdq_engine.sv
// Ring-buffer engine: head/tail pointers, count, cached end words, slot RAM.
// Depends on bdq_pkg and bdq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bdq_engine #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire bdq_pkg::req_type          req_item,
   output logic                           rsp_strobe,
   output bdq_pkg::rsp_type               rsp_item,
   input  wire logic [bdq_pkg::CAP_W-1:0] capacity
);

   localparam int          PTR_W   = $clog2(DEPTH);
   localparam logic [31:0] DEPTH_V = 32'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_PTR : p - 1'b1;
   endfunction

   function automatic logic at_limit(input logic [bdq_pkg::COUNT_W-1:0] cnt,
                                     input logic [bdq_pkg::CAP_W-1:0]   cap);
      return (cnt >= cap) || ({{(32 - bdq_pkg::COUNT_W){1'b0}}, cnt} >= DEPTH_V);
   endfunction

   bdq_pkg::state_type                    state_ff, state_in;
   logic [PTR_W-1:0]                      head_ff, head_in;
   logic [PTR_W-1:0]                      tail_ff, tail_in;
   logic [bdq_pkg::COUNT_W-1:0]           count_ff, count_in;
   logic signed [bdq_pkg::WORD_W-1:0]     front_ff, front_in;
   logic signed [bdq_pkg::WORD_W-1:0]     rear_ff, rear_in;
   logic                                  fill_front_ff, fill_front_in;
   bdq_pkg::rsp_type                      rsp_ff, rsp_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   logic                                  accept;
   logic                                  need_read;
   logic                                  full_now;
   logic                                  wr_en;
   logic [PTR_W-1:0]                      wr_addr;
   logic [PTR_W-1:0]                      rd_addr;
   logic [bdq_pkg::WORD_W-1:0]            rd_data;
   bdq_pkg::status_type                   status;
   logic signed [bdq_pkg::WORD_W-1:0]     popped;

   bdq_ram #(
      .WIDTH (bdq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_item.push_word),
      .rd_en   (need_read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (accept && need_read) begin
               state_in = bdq_pkg::ST_FILL;
            end
         end
         bdq_pkg::ST_FILL: begin
            state_in = bdq_pkg::ST_IDLE;
         end
         default: begin
            state_in = bdq_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      busy = 1'b0;
      case (state_ff)
         bdq_pkg::ST_IDLE: busy = 1'b0;
         bdq_pkg::ST_FILL: busy = 1'b1;
         default:          busy = 1'b1;
      endcase
   end

   assign accept   = start && !busy;
   assign full_now = at_limit(count_ff, capacity);

   // datapath
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      fill_front_in = fill_front_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      need_read     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      rd_addr       = head_ff;
      status        = bdq_pkg::STAT_DONE;
      popped        = bdq_pkg::NONE_WORD;

      if (accept) begin
         case (req_item.cmd)
            bdq_pkg::CMD_PUSH_FRONT: begin
               if (full_now) begin
                  status = bdq_pkg::STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = ring_prev(head_ff);
                  head_in  = ring_prev(head_ff);
                  count_in = count_ff + 1'b1;
                  front_in = req_item.push_word;
                  if (count_ff == '0) begin
                     rear_in = req_item.push_word;
                  end
               end
            end
            bdq_pkg::CMD_PUSH_REAR: begin
               if (full_now) begin
                  status = bdq_pkg::STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  tail_in  = ring_next(tail_ff);
                  count_in = count_ff + 1'b1;
                  rear_in  = req_item.push_word;
                  if (count_ff == '0) begin
                     front_in = req_item.push_word;
                  end
               end
            end
            bdq_pkg::CMD_POP_FRONT: begin
               if (count_ff == '0) begin
                  status = bdq_pkg::STAT_EMPTY;
               end else begin
                  popped        = front_ff;
                  head_in       = ring_next(head_ff);
                  count_in      = count_ff - 1'b1;
                  rd_addr       = ring_next(head_ff);
                  need_read     = (count_ff != bdq_pkg::COUNT_W'(1));
                  fill_front_in = 1'b1;
               end
            end
            default: begin
               if (count_ff == '0) begin
                  status = bdq_pkg::STAT_EMPTY;
               end else begin
                  popped        = rear_ff;
                  tail_in       = ring_prev(tail_ff);
                  count_in      = count_ff - 1'b1;
                  rd_addr       = ring_prev(ring_prev(tail_ff));
                  need_read     = (count_ff != bdq_pkg::COUNT_W'(1));
                  fill_front_in = 1'b0;
               end
            end
         endcase

         rsp_in.popped_word = popped;
         rsp_in.status      = status;
         rsp_in.entry_count = count_in;
         rsp_in.is_full     = at_limit(count_in, capacity);
         rsp_in.is_empty    = (count_in == '0);
         rsp_in.front_word  = (count_in == '0) ? bdq_pkg::NONE_WORD : front_in;
         rsp_in.rear_word   = (count_in == '0) ? bdq_pkg::NONE_WORD : rear_in;
         rsp_valid_in       = !need_read;
      end else if (state_ff == bdq_pkg::ST_FILL) begin
         // slot read returns the new end word
         if (fill_front_ff) begin
            front_in          = rd_data;
            rsp_in.front_word = rd_data;
         end else begin
            rear_in           = rd_data;
            rsp_in.rear_word  = rd_data;
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      rear_ff       <= rear_in;
      fill_front_ff <= fill_front_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bdq_checker.sv
// Port-level checks for the bounded double-ended queue, bound to the top level.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_strobe,
   input wire bdq_pkg::rsp_type rsp_item
);

   a_busy_no_beat: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("result beat while busy");

   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted operation neither busy nor answered");

   a_fill_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_strobe))
      else $error("read-back did not finish in one cycle");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.is_empty == (rsp_item.entry_count == '0)))
      else $error("empty flag disagrees with count");

   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.is_empty) |->
         (rsp_item.front_word == bdq_pkg::NONE_WORD &&
          rsp_item.rear_word == bdq_pkg::NONE_WORD))
      else $error("empty queue reports end words");

endmodule

bind bounded_double_ended_queue_unit bdq_checker u_bdq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire
